### rtl/core/modular_exponentiation_defines.svh
// Assertion macros for the modular exponentiation core.
// Clocked on i_clk and disabled while i_rst_n is low; empty when SYNTH is defined.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH
`ifndef SYNTH
`define ME_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
`define ME_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
`define ME_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ME_ASSERT(lbl, prop)
`define ME_ASSERT_IMP(lbl, ante, cons)
`define ME_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/core/modexp_pkg.sv
// Shared types and constants for the modular exponentiation core.
// No dependencies; imported by modexp_mulmod, modular_exponentiation, power_checker and tb.
package modexp_pkg;

    localparam int BASE_W = 31;
    localparam int EXP_W  = 63;
    localparam int CNT_W  = $clog2(BASE_W + 1);

    localparam logic [BASE_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } t_mul_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_BASE    = 6'b000010,
        S_NEXT    = 6'b000100,
        S_MUL_ACC = 6'b001000,
        S_MUL_SQ  = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

endpackage

### rtl/core/modexp_mulmod.sv
// Bit-serial interleaved modular multiplier: one operand bit per cycle, MSB first.
// Depends on modexp_pkg and modular_exponentiation_defines.svh.
`include "modular_exponentiation_defines.svh"
module modexp_mulmod #(
    parameter int MOD_BITS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  modexp_pkg::t_mul_ctl          i_ctl,
    input  logic [MOD_BITS-1:0]           i_a,
    input  logic [modexp_pkg::BASE_W-1:0] i_b,
    input  logic [MOD_BITS:0]             i_m,
    output modexp_pkg::t_mul_stat         o_stat,
    output logic [MOD_BITS-1:0]           o_prod
);
    import modexp_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [MOD_BITS-1:0] r_r;
    logic [MOD_BITS-1:0] r_a;
    logic [BASE_W-1:0]   r_b;
    logic [MOD_BITS:0]   r_m;

    logic [MOD_BITS+1:0] w_sum;
    logic [MOD_BITS+1:0] w_sub;
    logic [MOD_BITS+1:0] w_red;

    always_comb begin
        w_sum = {1'b0, r_r, 1'b0} + (r_b[BASE_W-1] ? (MOD_BITS+2)'(r_a) : '0);
        if (w_sum >= (MOD_BITS+2)'(r_m)) begin
            w_sub = w_sum - (MOD_BITS+2)'(r_m);
        end else begin
            w_sub = w_sum;
        end
        if (w_sub >= (MOD_BITS+2)'(r_m)) begin
            w_red = w_sub - (MOD_BITS+2)'(r_m);
        end else begin
            w_red = w_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_r <= '0;
            r_a <= i_a;
            r_b <= i_b;
            r_m <= i_m;
        end else if (r_busy) begin
            r_r <= w_red[MOD_BITS-1:0];
            r_b <= r_b << 1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_r;

    `ME_ASSERT_IMP(a_residue_bound, r_busy, {1'b0, r_r} < r_m)
    `ME_ASSERT_IMP(a_done_idle, r_done, !r_busy)
    `ME_ASSERT_NXT(a_start_busy, i_ctl.start, r_busy)

endmodule

### rtl/core/modular_exponentiation.sv
// Modular exponentiation, right-to-left square and multiply over a serial mulmod.
// A base reduction comes first, then one multiply or square at a time on the mulmod;
// at most 125 of them for a full 63-bit exponent; one item at a time.
// A result waits in an output register while the next request is taken.
// Reset (synchronous, active low) idles the sequencer and loads modulus 1000000007.
// Depends on modexp_pkg, modexp_mulmod and modular_exponentiation_defines.svh.
`include "modular_exponentiation_defines.svh"
module modular_exponentiation #(
    parameter int EXP_BITS = 63,
    parameter int MOD_BITS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_modulus_we,
    input  logic [modexp_pkg::BASE_W-1:0] i_modulus,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [modexp_pkg::BASE_W-1:0] i_base_value,
    input  logic [modexp_pkg::EXP_W-1:0]  i_exponent,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [modexp_pkg::BASE_W-1:0] o_power_result
);
    import modexp_pkg::*;

    localparam logic [MOD_BITS-1:0] MOD_RESET = MODULUS_RESET[MOD_BITS-1:0];

    t_state              r_state, n_state;
    logic [MOD_BITS-1:0] r_modulus;
    logic [EXP_BITS-1:0] r_exp, n_exp;
    logic [MOD_BITS-1:0] r_acc, n_acc;
    logic [MOD_BITS-1:0] r_sq, n_sq;
    logic                r_out_valid, n_out_valid;
    logic [MOD_BITS-1:0] r_out_data, n_out_data;

    t_mul_ctl            w_ctl;
    t_mul_stat           w_stat;
    logic [MOD_BITS-1:0] w_a;
    logic [BASE_W-1:0]   w_b;
    logic [MOD_BITS:0]   w_m_eff;
    logic [MOD_BITS-1:0] w_prod;
    logic [BASE_W-1:0]   w_sq_just;
    logic [EXP_BITS-1:0] w_exp_shr;

    assign w_m_eff   = {(r_modulus == '0), r_modulus};
    assign w_sq_just = BASE_W'(r_sq) << (BASE_W - MOD_BITS);
    assign w_exp_shr = r_exp >> 1;

    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_out_valid = r_out_valid && i_stall;
        n_out_data  = r_out_data;
        w_ctl.start = 1'b0;
        w_ctl.nbits = CNT_W'(MOD_BITS);
        w_a         = r_acc;
        w_b         = w_sq_just;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_exp       = i_exponent[EXP_BITS-1:0];
                    n_acc       = MOD_BITS'(1);
                    w_ctl.start = 1'b1;
                    w_ctl.nbits = CNT_W'(BASE_W);
                    w_a         = MOD_BITS'(1);
                    w_b         = i_base_value;
                    n_state     = S_BASE;
                end
            end
            S_BASE: begin
                if (w_stat.done) begin
                    n_sq    = w_prod;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_exp == '0) begin
                    n_state = S_DONE;
                end else if (r_exp[0]) begin
                    w_ctl.start = 1'b1;
                    n_state     = S_MUL_ACC;
                end else begin
                    n_exp = w_exp_shr;
                    if (w_exp_shr != '0) begin
                        w_ctl.start = 1'b1;
                        w_a         = r_sq;
                        n_state     = S_MUL_SQ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MUL_ACC: begin
                if (w_stat.done) begin
                    n_acc   = w_prod;
                    n_exp   = r_exp & ~EXP_BITS'(1);
                    n_state = S_NEXT;
                end
            end
            S_MUL_SQ: begin
                if (w_stat.done) begin
                    n_sq    = w_prod;
                    n_state = S_NEXT;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= MOD_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_modulus_we) begin
                r_modulus <= i_modulus[MOD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp      <= n_exp;
        r_acc      <= n_acc;
        r_sq       <= n_sq;
        r_out_data <= n_out_data;
    end

    modexp_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_m     (w_m_eff),
        .o_stat  (w_stat),
        .o_prod  (w_prod)
    );

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_power_result = BASE_W'(r_out_data);

    `ME_ASSERT_IMP(a_start_free, w_ctl.start, !w_stat.busy)
    `ME_ASSERT_IMP(a_acc_bound, r_state == S_DONE,
        ({1'b0, r_acc} < w_m_eff) || (r_acc == MOD_BITS'(1)))
    `ME_ASSERT_NXT(a_accept_base, (r_state == S_IDLE) && i_valid,
        (r_state == S_BASE) && w_stat.busy)

endmodule

### bench/power_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the modular exponentiation core: snoops the modulus port and both
// request/result channels, predicts every power in order and compares it.
// Depends on modexp_pkg.
module power_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_modulus_we,
    input  logic [modexp_pkg::BASE_W-1:0] i_modulus,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic [modexp_pkg::BASE_W-1:0] i_base_value,
    input  logic [modexp_pkg::EXP_W-1:0]  i_exponent,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_stall,
    input  logic [modexp_pkg::BASE_W-1:0] i_power_result,
    output int                            o_mismatches,
    output int                            o_outstanding
);
    import modexp_pkg::*;

    localparam int                REPORT_LIMIT = 10;
    localparam logic [BASE_W-1:0] WRAP_MASK    = '1;

    typedef struct {
        logic [BASE_W-1:0] base_value;
        logic [EXP_W-1:0]  exponent;
        logic [BASE_W-1:0] modulus;
        logic [BASE_W-1:0] power;
    } t_power_request;

    t_power_request    power_q[$];
    t_power_request    req;
    logic [BASE_W-1:0] modulus_q = MODULUS_RESET;

    // zero modulus wraps at 2^31
    function automatic longint unsigned residue(longint unsigned x, longint unsigned m);
        if (m == 0)
            return x & WRAP_MASK;
        return x % m;
    endfunction

    function automatic logic [BASE_W-1:0] power_mod(logic [BASE_W-1:0] b,
                                                    logic [EXP_W-1:0] e,
                                                    logic [BASE_W-1:0] m);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1;
        sq  = residue(b, m);
        for (int i = 0; i < EXP_W; i++) begin
            if (e[i])
                acc = residue(acc * sq, m);
            sq = residue(sq * sq, m);
        end
        return acc[BASE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_q = MODULUS_RESET;
            power_q.delete();
            o_mismatches  = 0;
            o_outstanding = 0;
        end else begin
            if (i_modulus_we)
                modulus_q = i_modulus;
            if (i_req_valid && !i_req_stall) begin
                req.base_value = i_base_value;
                req.exponent   = i_exponent;
                req.modulus    = modulus_q;
                req.power      = power_mod(i_base_value, i_exponent, modulus_q);
                power_q        = {power_q, req};
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (power_q.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT)
                        $display("unexpected result %0d with no request pending",
                                 i_power_result);
                end else begin
                    req = power_q.pop_front();
                    if (i_power_result !== req.power) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_LIMIT)
                            $display("mismatch: base %0d exp 0x%0h mod %0d: %s %0d, %s %0d",
                                     req.base_value, req.exponent, req.modulus,
                                     "expected", req.power, "got", i_power_result);
                    end
                end
            end
            o_outstanding = power_q.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Top of the modular exponentiation bench: clock, reset, bursty requests, result stalls
// and modulus phases; checking is left to power_checker, the verdict is given here.
// Depends on modexp_pkg, modular_exponentiation and power_checker.
module tb;
    import modexp_pkg::*;

    localparam int                PHASES          = 10;
    localparam int                ITEMS_PER_PHASE = 70;
    localparam int                SETTLE_CYCLES   = 4200;
    localparam longint            CYCLE_LIMIT     = 12_000_000;
    localparam logic [BASE_W-1:0] BASE_MAX        = '1;
    localparam logic [EXP_W-1:0]  EXP_MAX         = '1;
    localparam logic [EXP_W-1:0]  EXP_TOP         = {1'b1, {(EXP_W-1){1'b0}}};

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              modulus_we    = 1'b0;
    logic [BASE_W-1:0] modulus_wdata = '0;
    logic              req_valid     = 1'b0;
    logic              req_stall;
    logic [BASE_W-1:0] base_value    = '0;
    logic [EXP_W-1:0]  exponent      = '0;
    logic              rsp_valid;
    logic              rsp_stall     = 1'b0;
    logic [BASE_W-1:0] power_result;
    int                mismatches;
    int                outstanding;

    longint            cycles      = 0;
    int                burst_left  = 0;
    bit                no_gaps     = 1'b0;
    logic [BASE_W-1:0] modulus_now = MODULUS_RESET;
    logic [BASE_W-1:0] phase_modulus [PHASES];
    t_stall_mode       stall_mode  = STALL_NONE;
    int                stall_left  = 0;
    int unsigned       stall_tick  = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    modular_exponentiation dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_modulus_we   (modulus_we),
        .i_modulus      (modulus_wdata),
        .i_valid        (req_valid),
        .o_stall        (req_stall),
        .i_base_value   (base_value),
        .i_exponent     (exponent),
        .o_valid        (rsp_valid),
        .i_stall        (rsp_stall),
        .o_power_result (power_result)
    );

    power_checker power_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_modulus_we   (modulus_we),
        .i_modulus      (modulus_wdata),
        .i_req_valid    (req_valid),
        .i_req_stall    (req_stall),
        .i_base_value   (base_value),
        .i_exponent     (exponent),
        .i_rsp_valid    (rsp_valid),
        .i_rsp_stall    (rsp_stall),
        .i_power_result (power_result),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(100, 3000);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:     rsp_stall <= 1'b0;
                STALL_SPARSE:   rsp_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: rsp_stall <= (stall_tick[2:0] < 3);
                default:        rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    function automatic logic [BASE_W-1:0] pick_base(logic [BASE_W-1:0] m);
        case ($urandom_range(0, 7))
            0, 1, 2: return BASE_W'($urandom);
            3:       return (m == 0) ? BASE_W'($urandom) : BASE_W'($urandom % m);
            4:       return BASE_W'($urandom_range(0, 3));
            5:       return BASE_W'(m + $urandom_range(0, 2) - 1);
            6:       return BASE_W'(BASE_MAX - $urandom_range(0, 1));
            default: return BASE_W'(m * $urandom_range(2, 5));
        endcase
    endfunction

    function automatic logic [EXP_W-1:0] pick_exponent();
        logic [EXP_W-1:0] r;
        int               width;
        r = EXP_W'({$urandom, $urandom});
        case ($urandom_range(0, 15))
            0, 1: return EXP_W'($urandom_range(0, 2));
            2, 3, 4, 5, 6, 7, 8: begin
                width = $urandom_range(1, 12);
                return r & ((EXP_W'(1) << width) - 1);
            end
            9, 10, 11, 12: begin
                width = $urandom_range(13, 32);
                return r & ((EXP_W'(1) << width) - 1);
            end
            14:      return r | EXP_TOP;
            15:      return EXP_MAX >> $urandom_range(0, EXP_W - 1);
            default: return r;
        endcase
    endfunction

    task automatic issue(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap        = no_gaps ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_valid  <= 1'b1;
        base_value <= b;
        exponent   <= e;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_modulus(logic [BASE_W-1:0] v);
        modulus_we    <= 1'b1;
        modulus_wdata <= v;
        @(negedge clk);
        modulus_we    <= 1'b0;
        modulus_now    = v;
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue('0, '0);
        issue(BASE_MAX, '0);
        issue('0, EXP_W'(1));
        issue('0, EXP_MAX);
        issue(BASE_W'(1), EXP_MAX);
        issue(BASE_MAX, EXP_W'(1));
        issue(MODULUS_RESET, EXP_W'(1));
        issue(MODULUS_RESET, EXP_W'(5));
        issue(MODULUS_RESET + BASE_W'(1), EXP_MAX);
        issue(MODULUS_RESET - BASE_W'(1), EXP_W'(2));
        issue(BASE_W'(2), EXP_W'(30));
        issue(BASE_W'(2), EXP_W'(31));
        issue(BASE_W'(2), EXP_TOP);
        issue(BASE_W'(3), EXP_W'({(EXP_W+1)/2{2'b01}}));
        issue(BASE_W'(7), EXP_W'({(EXP_W+1)/2{2'b10}}));
        issue(BASE_W'(123456789), EXP_W'(MODULUS_RESET - BASE_W'(2)));
        issue(BASE_MAX, EXP_MAX);

        phase_modulus[0] = BASE_W'(1);
        phase_modulus[1] = BASE_W'(2);
        phase_modulus[2] = BASE_MAX;
        phase_modulus[3] = '0;
        phase_modulus[4] = BASE_W'(3);
        phase_modulus[5] = BASE_W'($urandom) | EXP_TOP[EXP_W-1 -: BASE_W];
        phase_modulus[6] = BASE_W'($urandom);
        phase_modulus[7] = BASE_W'($urandom_range(2, 1000));
        phase_modulus[8] = BASE_W'($urandom_range(65536, 1 << 20));
        phase_modulus[9] = MODULUS_RESET;

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_modulus(phase_modulus[p]);
            no_gaps = ($urandom_range(0, 3) == 0);
            issue(BASE_W'($urandom), '0);
            issue(modulus_now, EXP_W'($urandom_range(1, 40)));
            repeat (ITEMS_PER_PHASE)
                issue(pick_base(modulus_now), pick_exponent());
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/modexp_pkg.sv
rtl/core/modexp_mulmod.sv
rtl/core/modular_exponentiation.sv
bench/power_checker.sv
bench/tb.sv
